>>> hdl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam logic [15:0] BUF_UNITS_RESET = 16'd256;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_BAD4
  } u8u16_cls_t;

  typedef struct packed {
    u8u16_cls_t  cls;
    logic [6:0]  data;
  } u8u16_item_t;

endpackage

>>> hdl/u8u16_front.sv
module u8u16_front import u8u16_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_raw_byte,
  output logic        push,
  output u8u16_item_t push_item,
  input  logic        q_full
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.data = in_raw_byte[6:0];
    if (in_raw_byte == 8'h00) begin
      push_item.cls = CLS_ZERO;
    end else if (!in_raw_byte[7]) begin
      push_item.cls = CLS_ASCII;
    end else if (!in_raw_byte[6]) begin
      push_item.cls = CLS_CONT;
    end else if (!in_raw_byte[5]) begin
      push_item.cls = CLS_LEAD2;
    end else if (!in_raw_byte[4]) begin
      push_item.cls = CLS_LEAD3;
    end else begin
      push_item.cls = CLS_BAD4;
    end
  end

endmodule

>>> hdl/u8u16_fifo.sv
module u8u16_fifo import u8u16_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  u8u16_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output u8u16_item_t q_item
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hdl/u8u16_back.sv
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_buffer_units,
  input  logic        q_valid,
  input  u8u16_item_t q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_end_of_string,
  output logic        out_decode_error
);

  logic [15:0] buf_units_r;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] part_r, part_nxt;
  logic [15:0] units_r, units_nxt;
  logic        disc_r, disc_nxt;

  logic        out_valid_r;
  logic [15:0] out_unit_r;
  logic        out_eos_r;
  logic        out_err_r;

  logic        can_take;
  logic        take;
  logic        res_v, res_eos, res_err;
  logic [15:0] res_unit;
  logic        emit_req, fail_req, fail_nz;
  logic [15:0] emit_val;

  assign cfg_ready = 1'b1;
  assign can_take  = !out_valid_r || out_ready;
  assign take      = q_valid && can_take;
  assign pop       = take;

  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    units_nxt = units_r;
    disc_nxt  = disc_r;
    res_v     = 1'b0;
    res_unit  = '0;
    res_eos   = 1'b0;
    res_err   = 1'b0;
    emit_req  = 1'b0;
    emit_val  = '0;
    fail_req  = 1'b0;
    fail_nz   = 1'b0;

    if (take) begin
      if (disc_r) begin
        if (q_item.cls == CLS_ZERO) begin
          disc_nxt = 1'b0;
        end
      end else if (pend_r != 2'd0) begin
        if (q_item.cls != CLS_CONT) begin
          fail_req = 1'b1;
          fail_nz  = (q_item.cls != CLS_ZERO);
        end else if (pend_r == 2'd2) begin
          part_nxt = part_r | {4'h0, q_item.data[5:0], 6'h00};
          pend_nxt = 2'd1;
        end else begin
          emit_req = 1'b1;
          emit_val = part_r | {10'h000, q_item.data[5:0]};
        end
      end else begin
        unique case (q_item.cls)
          CLS_ZERO, CLS_ASCII: begin
            emit_req = 1'b1;
            emit_val = {9'h000, q_item.data};
          end
          CLS_LEAD2: begin
            part_nxt = {5'h00, q_item.data[4:0], 6'h00};
            pend_nxt = 2'd1;
          end
          CLS_LEAD3: begin
            part_nxt = {q_item.data[3:0], 12'h000};
            pend_nxt = 2'd2;
          end
          default: begin
            fail_req = 1'b1;
            fail_nz  = 1'b1;
          end
        endcase
      end
    end

    if (emit_req) begin
      if (units_r >= buf_units_r) begin
        fail_req = 1'b1;
        fail_nz  = (emit_val != '0);
      end else begin
        units_nxt = units_r + 1'b1;
        pend_nxt  = 2'd0;
        part_nxt  = '0;
        res_v     = 1'b1;
        res_unit  = emit_val;
        if (emit_val == '0) begin
          units_nxt = '0;
          res_eos   = 1'b1;
        end
      end
    end

    if (fail_req) begin
      pend_nxt  = 2'd0;
      part_nxt  = '0;
      units_nxt = '0;
      disc_nxt  = fail_nz;
      res_v     = 1'b1;
      res_unit  = '0;
      res_eos   = 1'b0;
      res_err   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_units_r <= BUF_UNITS_RESET;
      pend_r      <= 2'd0;
      part_r      <= '0;
      units_r     <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buf_units_r <= cfg_buffer_units;
      end
      pend_r  <= pend_nxt;
      part_r  <= part_nxt;
      units_r <= units_nxt;
      disc_r  <= disc_nxt;
      if (can_take) begin
        out_valid_r <= res_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_v) begin
      out_unit_r <= res_unit;
      out_eos_r  <= res_eos;
      out_err_r  <= res_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = out_unit_r;
  assign out_end_of_string = out_eos_r;
  assign out_decode_error  = out_err_r;

endmodule

>>> hdl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 (BMP) decoder. Bytes of a zero-terminated string enter on
// in_raw_byte; one 16-bit code unit leaves per completed 1-, 2- or 3-byte
// sequence, the terminator with out_end_of_string set. A malformed sequence
// or a unit beyond cfg_buffer_units (capacity including the terminator)
// gives one result with out_decode_error set, after which, unless the
// failing byte or unit was zero, bytes are dropped up to and including
// the next zero byte. One byte is accepted per cycle while the queue has
// room; a byte that completes a unit passes through the classifier queue
// and then the output register, where its result is held until taken.
// The queue between classifier and decoder holds QDEPTH bytes (default
// QUEUE_DEPTH), so it takes up to that many bytes while the output is
// stalled. Write the capacity register only while no string is in flight.
module utf8_to_utf16_decoder import u8u16_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_buffer_units,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_raw_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_end_of_string,
  output logic        out_decode_error
);

  logic        push;
  u8u16_item_t push_item;
  logic        q_full;
  logic        q_valid;
  u8u16_item_t q_item;
  logic        pop;

  u8u16_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw_byte (in_raw_byte),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  u8u16_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  u8u16_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_buffer_units  (cfg_buffer_units),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_unit     (out_code_unit),
    .out_end_of_string (out_end_of_string),
    .out_decode_error  (out_decode_error)
  );

endmodule

>>> test/utf8_to_utf16_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
    logic        err;
  } unit_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_buffer_units = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_raw_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_end_of_string;
  logic        out_decode_error;

  utf8_to_utf16_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_buffer_units  (cfg_buffer_units),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_byte       (in_raw_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_unit     (out_code_unit),
    .out_end_of_string (out_end_of_string),
    .out_decode_error  (out_decode_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  logic [15:0] cap_units = u8u16_pkg::BUF_UNITS_RESET;
  logic [1:0]  need_cnt = 2'd0;
  logic [15:0] acc_unit = 16'd0;
  logic [15:0] units_cnt = 16'd0;
  logic        dropping = 1'b0;

  logic [7:0]  pend_bytes [$];
  unit_res_t   unit_q [$];
  int          n_pushed = 0;
  int          n_accepted = 0;
  int          err_cnt = 0;
  int          cyc = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  bit          long_hold_req = 1'b0;
  bit          no_idle = 1'b0;

  task automatic clear_string();
    need_cnt = 2'd0;
    acc_unit = 16'd0;
    units_cnt = 16'd0;
    dropping = 1'b0;
  endtask

  task automatic raise_error(input logic [15:0] c);
    clear_string();
    if (c != 16'd0) dropping = 1'b1;
    unit_q.push_back('{unit: 16'd0, eos: 1'b0, err: 1'b1});
  endtask

  task automatic put_unit(input logic [15:0] c);
    if (units_cnt >= cap_units) begin
      raise_error(c);
    end else begin
      units_cnt = units_cnt + 16'd1;
      need_cnt = 2'd0;
      acc_unit = 16'd0;
      if (c == 16'd0) begin
        clear_string();
        unit_q.push_back('{unit: 16'd0, eos: 1'b1, err: 1'b0});
      end else begin
        unit_q.push_back('{unit: c, eos: 1'b0, err: 1'b0});
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (dropping) begin
      if (b == 8'd0) clear_string();
    end else if (need_cnt != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        raise_error({8'd0, b});
      end else if (need_cnt == 2'd2) begin
        acc_unit = acc_unit | {4'd0, b[5:0], 6'd0};
        need_cnt = 2'd1;
      end else begin
        put_unit(acc_unit | {10'd0, b[5:0]});
      end
    end else if (!b[7]) begin
      put_unit({8'd0, b});
    end else if (!b[6]) begin
      raise_error({8'd0, b});
    end else if (b[5]) begin
      if (b[4]) begin
        raise_error({8'd0, b});
      end else begin
        acc_unit = {b[3:0], 12'd0};
        need_cnt = 2'd2;
      end
    end else begin
      acc_unit = {5'd0, b[4:0], 6'd0};
      need_cnt = 2'd1;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_raw_byte);
        n_accepted++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pend_bytes.size() > 0 && !no_idle && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pend_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_raw_byte <= pend_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 60;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    unit_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (unit_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected item: unit %h eos %b err %b",
                   out_code_unit, out_end_of_string, out_decode_error);
      end else begin
        want = unit_q.pop_front();
        if (out_code_unit !== want.unit || out_end_of_string !== want.eos ||
            out_decode_error !== want.err) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected unit %h eos %b err %b, got unit %h eos %b err %b",
                     want.unit, want.eos, want.err,
                     out_code_unit, out_end_of_string, out_decode_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    pend_bytes.push_back(b);
    n_pushed++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic wait_drained();
    while (n_accepted != n_pushed || unit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_buffer_units <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_units = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_rand_string(input int max_chars);
    int n;
    int kind;
    n = $urandom_range(0, max_chars);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 39);
      if (kind < 16) begin
        put_byte(8'($urandom_range(1, 127)));
      end else if (kind < 25) begin
        put_byte(8'($urandom_range(8'hC0, 8'hDF)));
        put_byte(cont_byte());
      end else if (kind < 35) begin
        put_byte(8'($urandom_range(8'hE0, 8'hEF)));
        put_byte(cont_byte());
        put_byte(cont_byte());
      end else if (kind == 35) begin
        put_byte(cont_byte());
      end else if (kind == 36) begin
        put_byte(8'($urandom_range(8'hF0, 8'hFF)));
      end else if (kind == 37) begin
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        // broken or truncated sequence
        put_byte(8'($urandom_range(8'hC0, 8'hEF)));
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
      end
    end
    put_byte(8'h00);
  endtask

  initial begin
    logic [7:0] dir_bytes [31];
    logic [15:0] cap;
    int phase_end;

    dir_bytes = '{
      8'h41, 8'h7F, 8'h00,
      8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'h00,
      8'hEF, 8'hBF, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'h00,
      8'hC0, 8'h80,
      8'h80, 8'h41, 8'h00,
      8'hF0, 8'h9F, 8'h98, 8'h00,
      8'hC3, 8'h41, 8'h00,
      8'hE2, 8'h82, 8'h00,
      8'h00
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset capacity
    foreach (dir_bytes[i]) put_byte(dir_bytes[i]);
    wait_drained();

    // zero capacity: every string fails on its first unit
    write_cap(16'd0);
    put_byte(8'h00);
    put_byte(8'h41); put_byte(8'h42); put_byte(8'h00);
    put_byte(8'hC2); put_byte(8'hA9); put_byte(8'h00);
    wait_drained();

    // capacity 2: exact fit, terminator overflow, unit overflow
    write_cap(16'd2);
    put_byte(8'h41); put_byte(8'h00);
    put_byte(8'h41); put_byte(8'h42); put_byte(8'h00);
    put_byte(8'h41); put_byte(8'h42); put_byte(8'h43); put_byte(8'h00);
    put_byte(8'hE2); put_byte(8'h82); put_byte(8'hAC); put_byte(8'h00);
    wait_drained();

    // max capacity, output held off while input keeps coming
    write_cap(16'hFFFF);
    long_hold_req = 1'b1;
    phase_end = n_pushed + 80;
    while (n_pushed < phase_end) add_rand_string(8);
    wait_drained();

    while (n_pushed < 850) begin
      case ($urandom_range(0, 5))
        0:       cap = 16'($urandom_range(0, 3));
        1:       cap = 16'($urandom_range(4, 12));
        2:       cap = 16'd256;
        3:       cap = 16'hFFFF;
        4:       cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(1, 8));
      endcase
      write_cap(cap);
      phase_end = n_pushed + $urandom_range(40, 100);
      while (n_pushed < phase_end) add_rand_string(10);
      wait_drained();
    end

    // closing stretch at full rate
    write_cap(16'($urandom_range(3, 10)));
    no_idle = 1'b1;
    phase_end = n_pushed + 100;
    while (n_pushed < phase_end) add_rand_string(10);
    wait_drained();

    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_fifo.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_decoder.sv
test/utf8_to_utf16_decoder_tb.sv
